// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the rewriter RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_ALWAYS(label, !(expr), msg)

`endif

// ===== rtl/tpr_pkg.sv =====
// Types and byte constants for the typographic punctuation rewriter.
`default_nettype none

package tpr_pkg;

  // Input byte codes that the rewriter acts on
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;

  // UTF-8 bytes of the replacement characters
  localparam logic [7:0] UTF_LEAD    = 8'hE2;
  localparam logic [7:0] UTF_MID     = 8'h80;
  localparam logic [7:0] UTF_EM_DASH = 8'h94;
  localparam logic [7:0] UTF_EN_DASH = 8'h93;
  localparam logic [7:0] UTF_RDQUOTE = 8'h9D;
  localparam logic [7:0] UTF_RSQUOTE = 8'h99;
  localparam logic [7:0] UTF_ELLIPS  = 8'hA6;

  // Most output bytes that one input transaction can cause
  localparam int unsigned MAX_OUT = 6;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // A group of up to three output bytes; b[0] goes out first
  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][7:0] b;
  } seg_t;

  // Work for the serializer: bytes[0] goes out first, cnt is 1..MAX_OUT
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [2:0]              cnt;
    logic                    last;
  } desc_t;

endpackage

`default_nettype wire

// ===== rtl/tpr_front.sv =====
// Front end: tracks hyphen and dot runs and builds the output bytes of each transaction.
`default_nettype none

module tpr_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tpr_pkg::in_item_t in_data,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output tpr_pkg::desc_t        push_data
);

  `include "assert_macros.svh"

  logic [1:0] hyph_r, hyph_nxt;
  logic [1:0] dot_r, dot_nxt;

  logic       is_hyph, is_dot, fire;
  logic [1:0] h_inc, h_new, d_inc, d_new;
  logic       h_emit, d_emit;
  tpr_pkg::seg_t s0, s1, s2;

  // Flush of a pending hyphen run
  function automatic tpr_pkg::seg_t hyph_flush(input logic [1:0] run);
    tpr_pkg::seg_t s;
    s.len  = 2'd0;
    s.b[0] = tpr_pkg::CH_HYPHEN;
    s.b[1] = tpr_pkg::UTF_MID;
    s.b[2] = tpr_pkg::UTF_EN_DASH;
    if (run == 2'd2) begin
      s.len  = 2'd3;
      s.b[0] = tpr_pkg::UTF_LEAD;
    end else if (run == 2'd1) begin
      s.len = 2'd1;
    end
    return s;
  endfunction

  // Flush of a pending dot run: leftover dots pass as they are
  function automatic tpr_pkg::seg_t dot_flush(input logic [1:0] run);
    tpr_pkg::seg_t s;
    s.len  = run[1] ? 2'd2 : {1'b0, run[0]};
    s.b[0] = tpr_pkg::CH_DOT;
    s.b[1] = tpr_pkg::CH_DOT;
    s.b[2] = tpr_pkg::CH_DOT;
    return s;
  endfunction

  // Three-byte replacement character
  function automatic tpr_pkg::seg_t seg3(input logic [7:0] tail);
    tpr_pkg::seg_t s;
    s.len  = 2'd3;
    s.b[0] = tpr_pkg::UTF_LEAD;
    s.b[1] = tpr_pkg::UTF_MID;
    s.b[2] = tail;
    return s;
  endfunction

  assign is_hyph  = (in_data.in_byte == tpr_pkg::CH_HYPHEN);
  assign is_dot   = (in_data.in_byte == tpr_pkg::CH_DOT);
  assign in_ready = push_ready;
  assign fire     = in_valid && push_ready;

  // Advance the run counters
  assign h_inc  = hyph_r + 2'd1;
  assign h_emit = (h_inc == 2'd3);
  assign h_new  = h_emit ? 2'd0 : h_inc;
  assign d_inc  = dot_r + 2'd1;
  assign d_emit = (d_inc == 2'd3);
  assign d_new  = d_emit ? 2'd0 : d_inc;

  // Pick the three segments: flush of the other run, own output, end-of-string flush
  always_comb begin
    s0 = '0;
    s1 = '0;
    s2 = '0;
    priority if (is_hyph) begin
      s0 = dot_flush(dot_r);
      if (h_emit) s1 = seg3(tpr_pkg::UTF_EM_DASH);
      if (in_data.in_last) s2 = hyph_flush(h_new);
    end else if (is_dot) begin
      s0 = hyph_flush(hyph_r);
      if (d_emit) s1 = seg3(tpr_pkg::UTF_ELLIPS);
      if (in_data.in_last) s2 = dot_flush(d_new);
    end else begin
      s0 = (hyph_r != 2'd0) ? hyph_flush(hyph_r) : dot_flush(dot_r);
      priority if (in_data.in_byte == tpr_pkg::CH_DQUOTE) begin
        s1 = seg3(tpr_pkg::UTF_RDQUOTE);
      end else if (in_data.in_byte == tpr_pkg::CH_APOS) begin
        s1 = seg3(tpr_pkg::UTF_RSQUOTE);
      end else begin
        s1.len  = 2'd1;
        s1.b[0] = in_data.in_byte;
      end
    end
  end

  // Pack the segments back to back
  always_comb begin
    logic [2:0] l0, l1, pos, j1, j2;
    logic [3:0] total;
    l0    = {1'b0, s0.len};
    l1    = {1'b0, s1.len};
    total = {2'b00, s0.len} + {2'b00, s1.len} + {2'b00, s2.len};
    push_data.cnt  = total[2:0];
    push_data.last = in_data.in_last;
    for (int i = 0; i < tpr_pkg::MAX_OUT; i++) begin
      pos = 3'(i);
      j1  = pos - l0;
      j2  = pos - l0 - l1;
      if (pos < l0) begin
        push_data.bytes[i] = s0.b[pos[1:0]];
      end else if (pos < l0 + l1) begin
        push_data.bytes[i] = s1.b[j1[1:0]];
      end else begin
        push_data.bytes[i] = s2.b[j2[1:0]];
      end
    end
  end

  // Drop transactions that cause no output
  assign push_valid = in_valid && (push_data.cnt != 3'd0);

  // Next run state
  always_comb begin
    hyph_nxt = hyph_r;
    dot_nxt  = dot_r;
    if (fire) begin
      priority if (in_data.in_last) begin
        hyph_nxt = 2'd0;
        dot_nxt  = 2'd0;
      end else if (is_hyph) begin
        hyph_nxt = h_new;
        dot_nxt  = 2'd0;
      end else if (is_dot) begin
        hyph_nxt = 2'd0;
        dot_nxt  = d_new;
      end else begin
        hyph_nxt = 2'd0;
        dot_nxt  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyph_r <= 2'd0;
      dot_r  <= 2'd0;
    end else begin
      hyph_r <= hyph_nxt;
      dot_r  <= dot_nxt;
    end
  end

  `ASSERT_NEVER(a_runs_exclusive, (hyph_r != 2'd0) && (dot_r != 2'd0), "both runs pending")
  `ASSERT_ALWAYS(a_last_clears, (fire && in_data.in_last) |=> (hyph_r == 2'd0 && dot_r == 2'd0), "runs not cleared after string end")
  `ASSERT_NEVER(a_last_emits, fire && in_data.in_last && !push_valid, "string end gave no output")

endmodule

`default_nettype wire

// ===== rtl/tpr_queue.sv =====
// Short queue of output descriptors between the front end and the serializer.
`default_nettype none

module tpr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire tpr_pkg::desc_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output tpr_pkg::desc_t      pop_data
);

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tpr_pkg::desc_t mem [DEPTH];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed descriptor
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  `ASSERT_ALWAYS(a_ptr_gap, (count_r == '0 || count_r == CW'(DEPTH)) |-> (wr_ptr_r == rd_ptr_r), "queue pointers out of step")

endmodule

`default_nettype wire

// ===== rtl/tpr_back.sv =====
// Back end: sends the bytes of each descriptor out one per cycle while out_ready is high.
`default_nettype none

module tpr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire tpr_pkg::desc_t pop_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tpr_pkg::out_item_t  out_data
);

  `include "assert_macros.svh"

  tpr_pkg::desc_t cur_r, cur_nxt;
  logic           cur_valid_r, cur_valid_nxt;
  logic [2:0]     idx_r, idx_nxt;
  logic           last_byte, out_fire;

  assign last_byte = (idx_r == cur_r.cnt - 3'd1);
  assign out_valid = cur_valid_r;
  assign out_fire  = cur_valid_r && out_ready;
  assign pop_ready = !cur_valid_r || (out_ready && last_byte);

  assign out_data.out_byte = cur_r.bytes[idx_r];
  assign out_data.out_last = cur_r.last && last_byte;

  // Load the next descriptor, step through bytes, drop when done
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    priority if (pop_valid && pop_ready) begin
      cur_nxt       = pop_data;
      cur_valid_nxt = 1'b1;
      idx_nxt       = 3'd0;
    end else if (out_fire && last_byte) begin
      cur_valid_nxt = 1'b0;
      idx_nxt       = 3'd0;
    end else if (out_fire) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  `ASSERT_ALWAYS(a_idx_in_range, cur_valid_r |-> (cur_r.cnt != 3'd0 && idx_r < cur_r.cnt), "byte index past descriptor")
  `ASSERT_ALWAYS(a_step_one, (out_fire && !last_byte) |=> (cur_valid_r && idx_r == $past(idx_r) + 3'd1), "byte index skipped")

endmodule

`default_nettype wire

// ===== rtl/typographic_punctuation_rewriter_unit.sv =====
// Top level of the typographic punctuation rewriter.
`default_nettype none

// Rewrites a UTF-8 byte stream: hyphen runs become em and en dashes, dot runs
// become ellipses, and straight quotes become right curly quotes. Each input
// transaction is accepted while the queue has room and classified by the front
// end, which holds the pending hyphen and dot run counts; a transaction that
// yields output turns into a descriptor of 1 to 6 output bytes in a
// QUEUE_DEPTH-entry queue, and the serializer sends one output byte per cycle
// while out_ready is high. A transaction that yields n bytes holds the
// serializer until all n are sent; a run byte that yields nothing is not
// queued. Each descriptor is registered in the queue and then in the
// serializer before its first byte goes out. out_last marks the final output
// byte of each string.
module typographic_punctuation_rewriter_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tpr_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tpr_pkg::out_item_t     out_data
);

  logic           push_valid, push_ready;
  tpr_pkg::desc_t push_data;
  logic           pop_valid, pop_ready;
  tpr_pkg::desc_t pop_data;

  // Classify bytes and track runs
  tpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple front end and serializer
  tpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Send bytes out
  tpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
